[rtl/bsc_pkg.sv]
// Package: shared types, constants and helpers of the barometric compensation block.
package bsc_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned RAW_W = 19;
    localparam int unsigned DIV_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_AC1_AC2 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AC3_AC4 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B1_B2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MC_MD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OSS = 3'd5;

    localparam logic [1:0] OSS_RESET = 2'd2;

    localparam logic FUNC_TEMP = 1'b0;
    localparam logic FUNC_PRES = 1'b1;

    // Datapath step codes issued by the controller
    typedef enum logic [4:0] {
        OP_T_MUL   = 5'd0,
        OP_T_DIVSET = 5'd1,
        OP_T_FIN   = 5'd2,
        OP_P_SQ    = 5'd3,
        OP_P_A     = 5'd4,
        OP_P_B     = 5'd5,
        OP_P_C     = 5'd6,
        OP_P_D     = 5'd7,
        OP_P_E     = 5'd8,
        OP_P_F     = 5'd9,
        OP_P_B7    = 5'd10,
        OP_P_DIVSET = 5'd11,
        OP_P_G     = 5'd12,
        OP_P_H     = 5'd13,
        OP_P_I     = 5'd14,
        OP_P_J     = 5'd15,
        OP_P_FIN   = 5'd16,
        OP_NONE    = 5'd17
    } dp_op_t;

    typedef struct packed {
        logic   load;
        logic   step;
        dp_op_t op;
        logic   div_step;
    } dp_cmd_t;

    typedef struct packed {
        logic div_zero;
        logic div_done;
    } dp_sts_t;

    function automatic logic [31:0] sra32(input logic [31:0] v, input logic [4:0] n);
        sra32 = 32'($signed(v) >>> n);
    endfunction

endpackage

[rtl/bsc_ctrl.sv]
// Controller: sequences the datapath steps of one temperature or pressure item.
module bsc_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  logic                  func,
    input  logic                  out_busy,
    input  bsc_pkg::dp_sts_t      sts,
    output bsc_pkg::dp_cmd_t      cmd,
    output logic                  in_ready,
    output logic                  result_load
);
    import bsc_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RUN  = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_POST = 6'b001000,
        ST_DONE = 6'b010000,
        ST_HOLD = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    dp_op_t op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg <= OP_NONE;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        cmd.load = 1'b0;
        cmd.step = 1'b0;
        cmd.op = op_reg;
        cmd.div_step = 1'b0;
        in_ready = 1'b0;
        result_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_fire;
                if (in_fire)
                begin
                    state_next = ST_RUN;
                    op_next = (func == FUNC_TEMP) ? OP_T_MUL : OP_P_SQ;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                unique case (op_reg)
                    OP_T_DIVSET, OP_P_DIVSET:
                    begin
                        if (sts.div_zero)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_DIV;
                        end
                    end
                    OP_T_FIN, OP_P_FIN:
                    begin
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        op_next = dp_op_t'(op_reg + 5'd1);
                    end
                endcase
                // zero divisor in pressure shows up at the B4 check
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = ST_POST;
                end
            end
            ST_POST:
            begin
                state_next = ST_RUN;
                op_next = dp_op_t'(op_reg + 5'd1);
            end
            ST_DONE:
            begin
                if (!out_busy)
                begin
                    result_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_HOLD:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/bsc_dp.sv]
// Datapath: compensation arithmetic with a shared multiplier and a radix-2 divider.
module bsc_dp
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bsc_pkg::dp_cmd_t      cmd,
    input  logic                  func,
    input  logic [18:0]           raw_value,
    input  logic [31:0]           coef_ac1_ac2,
    input  logic [31:0]           coef_ac3_ac4,
    input  logic [31:0]           coef_ac5_ac6,
    input  logic [31:0]           coef_b1_b2,
    input  logic [31:0]           coef_mc_md,
    input  logic [1:0]            oversampling,
    output bsc_pkg::dp_sts_t      sts,
    output logic signed [31:0]    res_value,
    output logic                  res_error
);
    import bsc_pkg::*;

    logic [31:0] b6_reg, b6_next;
    logic [31:0] sq_reg, x1_reg, x2_reg, b3_reg, b4_reg, b7_reg, p_reg, t_reg;
    logic [18:0] raw_reg;
    logic [31:0] res_reg;
    logic        err_reg;
    logic        tfunc_reg;

    // divider: magnitude long division, one bit a cycle
    logic [31:0] dq_reg, dr_reg, dd_reg;
    logic [5:0]  dcnt_reg;
    logic        dneg_reg;

    logic signed [16:0] ac5_s, ac6_s, mc_s, md_s;
    logic signed [31:0] ac1, ac2, ac3, b1, b2;
    logic [31:0] ac4;
    logic signed [35:0] tprod;
    logic signed [31:0] tden;
    logic [31:0] mul_a, mul_b, mul_p;
    logic [32:0] rem_sh;
    logic [31:0] b7_shift;

    function automatic logic [31:0] raw_value_ext(input logic [18:0] r);
        raw_value_ext = {13'd0, r};
    endfunction

    assign ac5_s = {1'b0, coef_ac5_ac6[31:16]};
    assign ac6_s = {1'b0, coef_ac5_ac6[15:0]};
    assign mc_s = 17'($signed(coef_mc_md[31:16]));
    assign md_s = 17'($signed(coef_mc_md[15:0]));
    assign ac1 = 32'($signed(coef_ac1_ac2[31:16]));
    assign ac2 = 32'($signed(coef_ac1_ac2[15:0]));
    assign ac3 = 32'($signed(coef_ac3_ac4[31:16]));
    assign ac4 = {16'd0, coef_ac3_ac4[15:0]};
    assign b1 = 32'($signed(coef_b1_b2[31:16]));
    assign b2 = 32'($signed(coef_b1_b2[15:0]));

    // (UT - AC6) * AC5, 20b x 17b signed
    assign tprod = 36'($signed({1'b0, raw_reg}) - 36'(ac6_s)) * 36'(ac5_s);
    assign tden = x1_reg + 32'(md_s);
    assign b7_shift = 32'd50000 >> oversampling;

    // one 32x32 low-word multiplier shared by the pressure steps
    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (cmd.op)
            OP_P_SQ:  begin mul_a = b6_reg; mul_b = b6_reg; end
            OP_P_A:   begin mul_a = sq_reg; mul_b = b2; end
            OP_P_B:   begin mul_a = ac2; mul_b = b6_reg; end
            OP_P_C:   begin mul_a = ac3; mul_b = b6_reg; end
            OP_P_D:   begin mul_a = b1; mul_b = sq_reg; end
            OP_P_F:   begin mul_a = ac4; mul_b = t_reg + 32'd32768; end
            OP_P_B7:  begin mul_a = raw_value_ext(raw_reg) - b3_reg; mul_b = b7_shift; end
            OP_P_G:   begin mul_a = sra32(p_reg, 5'd8); mul_b = sra32(p_reg, 5'd8); end
            OP_P_H:   begin mul_a = x1_reg; mul_b = 32'd3038; end
            OP_P_I:   begin mul_a = 32'd0 - 32'd7357; mul_b = p_reg; end
            default:  begin mul_a = 32'd0; mul_b = 32'd0; end
        endcase
    end
    assign mul_p = 32'(mul_a * mul_b);

    assign rem_sh = {dr_reg, dq_reg[31]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b6_reg <= 32'd0;
        end
        else
        begin
            b6_reg <= b6_next;
        end
    end

    always_comb
    begin
        b6_next = b6_reg;
        if (cmd.step && cmd.op == OP_T_FIN)
        begin
            b6_next = x1_reg + x2_reg - 32'd4000;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            raw_reg <= raw_value;
            tfunc_reg <= func;
            err_reg <= 1'b0;
            res_reg <= 32'd0;
        end
        if (cmd.div_step)
        begin
            dq_reg <= {dq_reg[30:0], (rem_sh >= {1'b0, dd_reg})};
            dr_reg <= (rem_sh >= {1'b0, dd_reg}) ? 32'(rem_sh - {1'b0, dd_reg})
                                                 : rem_sh[31:0];
            dcnt_reg <= dcnt_reg - 6'd1;
        end
        if (cmd.step)
        begin
            unique case (cmd.op)
                OP_T_MUL:
                begin
                    x1_reg <= 32'(tprod >>> 15);
                end
                OP_T_DIVSET:
                begin
                    // quotient of MC*2048 by X1+MD, signs applied after
                    dneg_reg <= mc_s[16] ^ tden[31];
                    dq_reg <= mc_s[16] ? 32'(-(32'(mc_s) <<< 11)) : 32'(32'(mc_s) <<< 11);
                    dd_reg <= tden[31] ? 32'(-tden) : tden;
                    dr_reg <= 32'd0;
                    dcnt_reg <= 6'd32;
                    if (tden == 32'd0)
                    begin
                        err_reg <= 1'b1;
                    end
                end
                OP_T_FIN:
                begin
                    res_reg <= sra32(x1_reg + x2_reg + 32'd8, 5'd4);
                end
                OP_P_SQ:  sq_reg <= sra32(mul_p, 5'd12);
                OP_P_A:   x1_reg <= sra32(mul_p, 5'd11);
                OP_P_B:
                begin
                    b3_reg <= sra32(((32'(ac1 << 2) + x1_reg + sra32(mul_p, 5'd11))
                                     << oversampling) + 32'd2, 5'd2);
                end
                OP_P_C:   x1_reg <= sra32(mul_p, 5'd13);
                OP_P_D:   x2_reg <= sra32(mul_p, 5'd16);
                OP_P_E:   t_reg <= sra32(x1_reg + x2_reg + 32'd2, 5'd2);
                OP_P_F:   b4_reg <= mul_p >> 15;
                OP_P_B7:  b7_reg <= mul_p;
                OP_P_DIVSET:
                begin
                    dneg_reg <= 1'b0;
                    dq_reg <= b7_reg[31] ? b7_reg : {b7_reg[30:0], 1'b0};
                    dd_reg <= b4_reg;
                    dr_reg <= 32'd0;
                    dcnt_reg <= 6'd32;
                    if (b4_reg == 32'd0)
                    begin
                        err_reg <= 1'b1;
                    end
                end
                OP_P_G:   x1_reg <= mul_p;
                OP_P_H:   x1_reg <= sra32(mul_p, 5'd16);
                OP_P_I:   x2_reg <= sra32(mul_p, 5'd16);
                OP_P_J:   t_reg <= sra32(x1_reg + x2_reg + 32'd3791, 5'd4);
                OP_P_FIN: res_reg <= p_reg + t_reg;
                default:  ;
            endcase
        end
        // fold the finished quotient back in on the cycle after the last bit
        if (!cmd.div_step && !cmd.step && !cmd.load && dcnt_reg == 6'd0)
        begin
            if (tfunc_reg == FUNC_TEMP)
            begin
                x2_reg <= dneg_reg ? 32'(-dq_reg) : dq_reg;
            end
            else
            begin
                p_reg <= b7_reg[31] ? {dq_reg[30:0], 1'b0} : dq_reg;
            end
            dcnt_reg <= 6'd63;
        end
    end

    assign sts.div_zero = (cmd.op == OP_T_DIVSET) ? (tden == 32'd0) : (b4_reg == 32'd0);
    assign sts.div_done = (dcnt_reg == 6'd1);
    assign res_value = res_reg;
    assign res_error = err_reg;

endmodule

[rtl/barometric_sensor_compensation.sv]
// Top level: register file, output register, controller and datapath.
//
// Compensates raw barometric sensor readings with the factory calibration words.
// A temperature item (func 0) returns 0.1 degC and stores the correction term used
// by later pressure items (func 1), which return Pa. One item is in work at a time:
// it passes through the sequence of shared-multiplier steps and the 32-step radix-2
// divider, then waits in its done state while the previous result is unread. A zero
// divisor returns 0 with div_error set and skips the divider. The result register
// lets the next item be accepted while a result waits.
module barometric_sensor_compensation
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [bsc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [bsc_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   func,
    input  logic [18:0]                            raw_value,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [31:0]                     result_value,
    output logic                                   div_error
);
    import bsc_pkg::*;

    logic [31:0] ac1_ac2_reg, ac3_ac4_reg, ac5_ac6_reg, b1_b2_reg, mc_md_reg;
    logic [1:0]  oss_reg;
    logic        out_valid_reg;
    logic signed [31:0] result_reg;
    logic        error_reg;
    dp_cmd_t     cmd;
    dp_sts_t     sts;
    logic        result_load;
    logic        ctrl_ready;
    logic signed [31:0] dp_value;
    logic        dp_error;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac1_ac2_reg <= 32'd0;
            ac3_ac4_reg <= 32'd0;
            ac5_ac6_reg <= 32'd0;
            b1_b2_reg <= 32'd0;
            mc_md_reg <= 32'd0;
            oss_reg <= OSS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_AC1_AC2: ac1_ac2_reg <= cfg_data;
                REG_AC3_AC4: ac3_ac4_reg <= cfg_data;
                REG_AC5_AC6: ac5_ac6_reg <= cfg_data;
                REG_B1_B2:   b1_b2_reg <= cfg_data;
                REG_MC_MD:   mc_md_reg <= cfg_data;
                REG_OSS:     oss_reg <= cfg_data[1:0];
                default:     ;
            endcase
        end
    end

    assign in_ready = ctrl_ready;

    bsc_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_valid && ctrl_ready),
        .func        (func),
        .out_busy    (out_valid_reg && !out_ready),
        .sts         (sts),
        .cmd         (cmd),
        .in_ready    (ctrl_ready),
        .result_load (result_load)
    );

    bsc_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .func         (func),
        .raw_value    (raw_value),
        .coef_ac1_ac2 (ac1_ac2_reg),
        .coef_ac3_ac4 (ac3_ac4_reg),
        .coef_ac5_ac6 (ac5_ac6_reg),
        .coef_b1_b2   (b1_b2_reg),
        .coef_mc_md   (mc_md_reg),
        .oversampling (oss_reg),
        .sts          (sts),
        .res_value    (dp_value),
        .res_error    (dp_error)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            result_reg <= dp_value;
            error_reg <= dp_error;
        end
    end

    assign out_valid = out_valid_reg;
    assign result_value = result_reg;
    assign div_error = error_reg;

endmodule

[rtl/bsc_checker.sv]
// Port checker for the barometric compensation block, bound to the top level.
module bsc_port_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic signed [31:0] result_value,
    input logic        div_error
);
    // a new item is never taken the cycle after one was taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second beat accepted while busy");

    // a result does not rise directly after an accepted item
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("result beat too early");

    // an error result carries zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && div_error) |-> (result_value == 32'sd0))
        else $error("error beat with nonzero value");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(result_value)))
        else $error("stalled result beat changed");

endmodule

bind barometric_sensor_compensation bsc_port_checker u_bsc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .div_error    (div_error)
);
